/* design/sqch_pkg.sv */
`timescale 1ns / 1ps

package sqch_pkg;

	// event codes carried in op
	localparam logic [2:0] OP_WRITE    = 3'd0;
	localparam logic [2:0] OP_READ     = 3'd1;
	localparam logic [2:0] OP_TIMER    = 3'd2;
	localparam logic [2:0] OP_LENGTH   = 3'd3;
	localparam logic [2:0] OP_ENVELOPE = 3'd4;
	localparam logic [2:0] OP_SWEEP    = 3'd5;

	// register offsets
	localparam logic [2:0] REG_SWEEP   = 3'd0;
	localparam logic [2:0] REG_DUTY    = 3'd1;
	localparam logic [2:0] REG_ENV     = 3'd2;
	localparam logic [2:0] REG_FREQ_LO = 3'd3;
	localparam logic [2:0] REG_FREQ_HI = 3'd4;

	localparam logic [11:0] PERIOD_BASE  = 12'd2048;
	localparam logic [6:0]  LENGTH_FULL  = 7'd64;
	localparam logic [3:0]  SWEEP_RELOAD = 4'd8;
	localparam logic [7:0]  RD_DUTY_MASK = 8'h3F;
	localparam logic [7:0]  RD_HI_MASK   = 8'hBF;
	localparam logic [7:0]  RD_SWEEP_MSB = 8'h80;
	localparam logic [7:0]  RD_NONE      = 8'hFF;

	// result of one sweep frequency calculation
	typedef struct packed {
		logic [10:0] freq;
		logic        overflow;
	} sweep_res_t;

	// standard 12.5/25/50/75 percent duty patterns, msb first
	function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
		logic [7:0] wave;
		case (sel)
			2'd0:    wave = 8'h80;
			2'd1:    wave = 8'h81;
			2'd2:    wave = 8'hE1;
			default: wave = 8'h7E;
		endcase
		return wave[3'd7 - pos];
	endfunction

endpackage

/* design/square_channel_with_sweep.sv */
`timescale 1ns / 1ps

// square-wave sound channel with frequency sweep, volume envelope and length counter
// input channel: in_valid/in_ready carry one item = op, reg_offset, write_data;
//   op selects register write, register read, period-timer clock, length step,
//   envelope step or sweep step
// output channel: out_valid/out_ready carry exactly one item per input item:
//   read_data (register value on a read, else 0), sample_out and channel_on,
//   all taken from the channel state after that item
// order: an accepted item sits in the input stage, and its result is registered in the
//   result register once that register is free or emptying; out_valid comes from there
// throughput: one item per cycle while out_ready stays high; the whole update
//   (including two chained sweep calculations) is one combinational pass between
//   the input stage and the result register
// stall: when out_ready is low the result register holds, the input stage
//   holds its item, and in_ready drops only once both are full
// reset: arst_n clears every channel register to zero (channel off, volume 0)
//   and empties both stages; the first item can be taken right after release
module square_channel_with_sweep (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] op,
	input  logic [2:0] reg_offset,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic [3:0] sample_out,
	output logic       channel_on
);

	// input stage
	logic       valid_s1;
	logic [2:0] op_s1;
	logic [2:0] off_s1;
	logic [7:0] data_s1;
	logic       advance;

	// channel state
	logic [13:0] period_count_q;
	logic [10:0] freq_q;
	logic [10:0] shadow_q;
	logic [3:0]  sweep_count_q;
	logic [2:0]  env_count_q;
	logic [6:0]  length_q;
	logic [2:0]  duty_pos_q;
	logic [3:0]  volume_q;
	logic        sweep_active_q;
	logic        enabled_q;
	logic [4:0]  dac_q;
	logic [2:0]  sweep_period_q;
	logic        sweep_negate_q;
	logic [2:0]  sweep_shift_q;
	logic [1:0]  duty_sel_q;
	logic [3:0]  init_volume_q;
	logic        env_inc_q;
	logic [2:0]  env_period_q;
	logic        length_en_q;

	// next state
	logic [13:0] period_count_d;
	logic [10:0] freq_d;
	logic [10:0] shadow_d;
	logic [3:0]  sweep_count_d;
	logic [2:0]  env_count_d;
	logic [6:0]  length_d;
	logic [2:0]  duty_pos_d;
	logic [3:0]  volume_d;
	logic        sweep_active_d;
	logic        enabled_d;
	logic [4:0]  dac_d;
	logic [2:0]  sweep_period_d;
	logic        sweep_negate_d;
	logic [2:0]  sweep_shift_d;
	logic [1:0]  duty_sel_d;
	logic [3:0]  init_volume_d;
	logic        env_inc_d;
	logic [2:0]  env_period_d;
	logic        length_en_d;
	logic [7:0]  rd_d;
	logic [3:0]  sample_d;

	// helpers
	logic [10:0] trig_freq;
	logic [10:0] calc_a_shadow;
	logic [11:0] reload_base;
	logic [13:0] reload_count;
	logic [2:0]  env_dec;
	logic [3:0]  sweep_dec;
	logic [3:0]  sweep_reload;

	sqch_pkg::sweep_res_t calc_a;
	sqch_pkg::sweep_res_t calc_b;

	// handshake: the input stage moves on whenever the result register is free or emptying
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op;
			off_s1  <= reg_offset;
			data_s1 <= write_data;
		end
	end

	// frequency as it stands after a write to the high byte, used for the trigger
	assign trig_freq     = {data_s1[2:0], freq_q[7:0]};
	// first calculation: trigger check or sweep step; second one rechecks the new shadow
	assign calc_a_shadow = (op_s1 == sqch_pkg::OP_SWEEP) ? shadow_q : trig_freq;

	sqch_sweep_calc u_calc_a (
		.shadow (calc_a_shadow),
		.negate (sweep_negate_q),
		.shift  (sweep_shift_q),
		.res    (calc_a)
	);

	sqch_sweep_calc u_calc_b (
		.shadow (calc_a.freq),
		.negate (sweep_negate_q),
		.shift  (sweep_shift_q),
		.res    (calc_b)
	);

	assign reload_base  = sqch_pkg::PERIOD_BASE - {1'b0, freq_q};
	assign reload_count = {reload_base, 2'b00};
	assign env_dec      = (env_count_q != 3'd0) ? (env_count_q - 3'd1) : 3'd0;
	assign sweep_dec    = (sweep_count_q != 4'd0) ? (sweep_count_q - 4'd1) : 4'd0;
	assign sweep_reload = (sweep_period_q != 3'd0) ? {1'b0, sweep_period_q}
		: sqch_pkg::SWEEP_RELOAD;

	always_comb begin
		period_count_d = period_count_q;
		freq_d         = freq_q;
		shadow_d       = shadow_q;
		sweep_count_d  = sweep_count_q;
		env_count_d    = env_count_q;
		length_d       = length_q;
		duty_pos_d     = duty_pos_q;
		volume_d       = volume_q;
		sweep_active_d = sweep_active_q;
		enabled_d      = enabled_q;
		dac_d          = dac_q;
		sweep_period_d = sweep_period_q;
		sweep_negate_d = sweep_negate_q;
		sweep_shift_d  = sweep_shift_q;
		duty_sel_d     = duty_sel_q;
		init_volume_d  = init_volume_q;
		env_inc_d      = env_inc_q;
		env_period_d   = env_period_q;
		length_en_d    = length_en_q;
		rd_d           = 8'h00;

		case (op_s1)
			sqch_pkg::OP_WRITE: begin
				case (off_s1)
					sqch_pkg::REG_SWEEP: begin
						sweep_period_d = data_s1[6:4];
						sweep_negate_d = data_s1[3];
						sweep_shift_d  = data_s1[2:0];
					end
					sqch_pkg::REG_DUTY: begin
						duty_sel_d = data_s1[7:6];
						length_d   = sqch_pkg::LENGTH_FULL - {1'b0, data_s1[5:0]};
					end
					sqch_pkg::REG_ENV: begin
						init_volume_d = data_s1[7:4];
						env_inc_d     = data_s1[3];
						env_period_d  = data_s1[2:0];
						dac_d         = data_s1[7:3];
						// dac off turns the channel off at once
						if (data_s1[7:3] == 5'd0) begin
							enabled_d = 1'b0;
						end
					end
					sqch_pkg::REG_FREQ_LO: begin
						freq_d = {freq_q[10:8], data_s1};
					end
					sqch_pkg::REG_FREQ_HI: begin
						freq_d      = trig_freq;
						length_en_d = data_s1[6];
						// trigger only takes effect while the dac is on
						if (data_s1[7] && dac_q != 5'd0) begin
							if (length_q == 7'd0) begin
								length_d = sqch_pkg::LENGTH_FULL;
							end
							enabled_d      = 1'b1;
							env_count_d    = env_period_q;
							volume_d       = init_volume_q;
							shadow_d       = trig_freq;
							sweep_count_d  = sweep_reload;
							sweep_active_d = (sweep_period_q != 3'd0) || (sweep_shift_q != 3'd0);
							if (sweep_shift_q != 3'd0 && calc_a.overflow) begin
								enabled_d = 1'b0;
							end
						end
					end
					default: begin
					end
				endcase
			end
			sqch_pkg::OP_READ: begin
				case (off_s1)
					sqch_pkg::REG_SWEEP:
						rd_d = sqch_pkg::RD_SWEEP_MSB
							| {1'b0, sweep_period_q, sweep_negate_q, sweep_shift_q};
					sqch_pkg::REG_DUTY:
						rd_d = {duty_sel_q, 6'd0} | sqch_pkg::RD_DUTY_MASK;
					sqch_pkg::REG_ENV:
						rd_d = {init_volume_q, env_inc_q, env_period_q};
					sqch_pkg::REG_FREQ_HI:
						rd_d = {1'b0, length_en_q, 6'd0} | sqch_pkg::RD_HI_MASK;
					default:
						rd_d = sqch_pkg::RD_NONE;
				endcase
			end
			sqch_pkg::OP_TIMER: begin
				// reload from the frequency and advance the duty step on reaching zero
				if (period_count_q == 14'd0) begin
					period_count_d = reload_count - 14'd1;
					duty_pos_d     = duty_pos_q + 3'd1;
				end else begin
					period_count_d = period_count_q - 14'd1;
				end
			end
			sqch_pkg::OP_LENGTH: begin
				if (length_en_q && length_q != 7'd0) begin
					length_d = length_q - 7'd1;
					if (length_q == 7'd1) begin
						enabled_d = 1'b0;
					end
				end
			end
			sqch_pkg::OP_ENVELOPE: begin
				// period zero halts the envelope
				if (env_period_q != 3'd0) begin
					env_count_d = env_dec;
					if (env_dec == 3'd0) begin
						env_count_d = env_period_q;
						if (env_inc_q && volume_q != 4'hF) begin
							volume_d = volume_q + 4'd1;
						end else if (!env_inc_q && volume_q != 4'd0) begin
							volume_d = volume_q - 4'd1;
						end
					end
				end
			end
			sqch_pkg::OP_SWEEP: begin
				sweep_count_d = sweep_dec;
				if (sweep_dec == 4'd0) begin
					sweep_count_d = sweep_reload;
					if (sweep_active_q && sweep_period_q != 3'd0) begin
						if (calc_a.overflow) begin
							enabled_d = 1'b0;
						end else if (sweep_shift_q != 3'd0) begin
							freq_d   = calc_a.freq;
							shadow_d = calc_a.freq;
							// the new frequency is checked once more
							if (calc_b.overflow) begin
								enabled_d = 1'b0;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase

		// sample from the state after this item
		if (dac_d != 5'd0 && enabled_d && sqch_pkg::duty_bit(duty_sel_d, duty_pos_d)) begin
			sample_d = volume_d;
		end else begin
			sample_d = 4'd0;
		end
	end

	// channel state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_count_q <= '0;
			freq_q         <= '0;
			shadow_q       <= '0;
			sweep_count_q  <= '0;
			env_count_q    <= '0;
			length_q       <= '0;
			duty_pos_q     <= '0;
			volume_q       <= '0;
			sweep_active_q <= 1'b0;
			enabled_q      <= 1'b0;
			dac_q          <= '0;
			sweep_period_q <= '0;
			sweep_negate_q <= 1'b0;
			sweep_shift_q  <= '0;
			duty_sel_q     <= '0;
			init_volume_q  <= '0;
			env_inc_q      <= 1'b0;
			env_period_q   <= '0;
			length_en_q    <= 1'b0;
		end else if (advance) begin
			period_count_q <= period_count_d;
			freq_q         <= freq_d;
			shadow_q       <= shadow_d;
			sweep_count_q  <= sweep_count_d;
			env_count_q    <= env_count_d;
			length_q       <= length_d;
			duty_pos_q     <= duty_pos_d;
			volume_q       <= volume_d;
			sweep_active_q <= sweep_active_d;
			enabled_q      <= enabled_d;
			dac_q          <= dac_d;
			sweep_period_q <= sweep_period_d;
			sweep_negate_q <= sweep_negate_d;
			sweep_shift_q  <= sweep_shift_d;
			duty_sel_q     <= duty_sel_d;
			init_volume_q  <= init_volume_d;
			env_inc_q      <= env_inc_d;
			env_period_q   <= env_period_d;
			length_en_q    <= length_en_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data  <= rd_d;
			sample_out <= sample_d;
			channel_on <= enabled_d;
		end
	end

	// the channel is never on with the dac off
	a_on_needs_dac: assert property (@(posedge clk) disable iff (!arst_n)
		enabled_q |-> (dac_q != 5'd0))
		else $error("channel enabled with dac off");

	// a nonzero sample only comes from an enabled channel
	a_sample_needs_on: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && sample_out != 4'd0) |-> channel_on)
		else $error("sample present while channel off");

	// length and sweep counters stay within their load values
	a_counter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(length_q <= sqch_pkg::LENGTH_FULL) && (sweep_count_q <= sqch_pkg::SWEEP_RELOAD))
		else $error("length or sweep counter out of range");

	// a stalled result register keeps the input stage from advancing
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !advance)
		else $error("input stage advanced into a full result register");

endmodule

/* design/sqch_sweep_calc.sv */
`timescale 1ns / 1ps

module sqch_sweep_calc (
	input  logic [10:0]         shadow,
	input  logic                negate,
	input  logic [2:0]          shift,
	output sqch_pkg::sweep_res_t res
);

	logic [11:0] delta;
	logic [11:0] nf;

	// shadow minus its own shifted copy never goes negative
	assign delta = {1'b0, shadow >> shift};
	assign nf    = negate ? ({1'b0, shadow} - delta) : ({1'b0, shadow} + delta);

	assign res.freq     = nf[10:0];
	assign res.overflow = nf[11];

endmodule

/* verif/square_channel_with_sweep_tb.sv */
`timescale 1ns / 1ps

module square_channel_with_sweep_tb;

	// codes that the block ignores or answers with all ones
	localparam logic [2:0] OP_UNUSED6  = 3'd6;
	localparam logic [2:0] OP_UNUSED7  = 3'd7;
	localparam logic [2:0] REG_UNUSED5 = 3'd5;
	localparam logic [2:0] REG_UNUSED6 = 3'd6;
	localparam logic [2:0] REG_UNUSED7 = 3'd7;

	// duty patterns packed side by side, pattern n in bits 8n+7..8n, msb played first
	localparam logic [31:0] DUTY_WAVES = {8'h7E, 8'hE1, 8'h81, 8'h80};

	localparam int RANDOM_ITEMS      = 520;
	localparam int LONG_STALL_CYCLES = 60;
	localparam int WATCHDOG_LIMIT    = 2000;
	localparam int SETTLE_CYCLES     = 8;
	localparam int MAX_REPORTS       = 10;

	// one result item as the block should present it
	typedef struct packed {
		logic [7:0] read_data;
		logic [3:0] level;
		logic       enabled;
	} chan_out_t;

	logic       clk;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [2:0] op         = '0;
	logic [2:0] reg_offset = '0;
	logic [7:0] write_data = '0;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic [7:0] read_data;
	logic [3:0] sample_out;
	logic       channel_on;

	square_channel_with_sweep dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.reg_offset (reg_offset),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.sample_out (sample_out),
		.channel_on (channel_on)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// channel state as the predictor tracks it, all zero out of reset
	// ------------------------------------------------------------------
	logic [13:0] period_left = '0;   // period timer countdown
	logic [10:0] freq_reg    = '0;
	logic [10:0] freq_shadow = '0;   // sweep works on this copy
	logic [3:0]  sweep_left  = '0;
	logic [2:0]  env_left    = '0;
	logic [6:0]  len_left    = '0;
	logic [2:0]  wave_pos    = '0;
	logic [3:0]  volume      = '0;
	logic        sweep_live  = 1'b0;
	logic        chan_live   = 1'b0;
	logic [4:0]  dac_on_bits = '0;   // envelope bits 7:3, zero means dac off
	logic [2:0]  sweep_rate  = '0;
	logic        sweep_down  = 1'b0;
	logic [2:0]  sweep_bits  = '0;
	logic [1:0]  wave_sel    = '0;
	logic [3:0]  vol_start   = '0;
	logic        env_rise    = 1'b0;
	logic [2:0]  env_rate    = '0;
	logic        len_gate    = 1'b0;

	chan_out_t chan_out_q[$];   // results still owed by the block, oldest first

	// bookkeeping for checks and the summary
	int  mismatches     = 0;
	int  results_seen   = 0;
	int  on_results     = 0;
	int  audible        = 0;
	int  items_sent     = 0;
	int  counted_items  = 0;   // items the block does not simply ignore
	int  idle_cycles    = 0;
	int  in_stall_count = 0;
	bit  tx_gaps_on     = 1'b1;
	bit  long_stall_req = 1'b0;
	int  rx_hold_left   = 0;
	int  rx_mode_left   = 0;
	bit  rx_choppy      = 1'b0;
	chan_out_t want, got;

	// next sweep frequency from the shadow copy, 12 bits so overflow shows in bit 11
	function automatic logic [11:0] sweep_target();
		logic [11:0] delta;
		delta = {1'b0, freq_shadow} >> sweep_bits;
		return sweep_down ? ({1'b0, freq_shadow} - delta) : ({1'b0, freq_shadow} + delta);
	endfunction

	// apply one accepted item to the tracked state and queue the result it owes
	task automatic apply_event(input logic [2:0] ev, input logic [2:0] off, input logic [7:0] d);
		chan_out_t   res;
		logic [11:0] nf;
		res.read_data = '0;
		case (ev)
			sqch_pkg::OP_WRITE: begin
				case (off)
					sqch_pkg::REG_SWEEP: begin
						sweep_rate = d[6:4];
						sweep_down = d[3];
						sweep_bits = d[2:0];
					end
					sqch_pkg::REG_DUTY: begin
						wave_sel = d[7:6];
						len_left = sqch_pkg::LENGTH_FULL - {1'b0, d[5:0]};
					end
					sqch_pkg::REG_ENV: begin
						vol_start   = d[7:4];
						env_rise    = d[3];
						env_rate    = d[2:0];
						dac_on_bits = d[7:3];
						if (dac_on_bits == '0)
							chan_live = 1'b0;
					end
					sqch_pkg::REG_FREQ_LO: freq_reg[7:0] = d;
					sqch_pkg::REG_FREQ_HI: begin
						freq_reg[10:8] = d[2:0];
						len_gate = d[6];
						// trigger only takes effect with the dac powered
						if (d[7] && dac_on_bits != '0) begin
							if (len_left == '0)
								len_left = sqch_pkg::LENGTH_FULL;
							chan_live   = 1'b1;
							env_left    = env_rate;
							volume      = vol_start;
							freq_shadow = freq_reg;
							sweep_left  = (sweep_rate != '0) ? {1'b0, sweep_rate}
								: sqch_pkg::SWEEP_RELOAD;
							sweep_live  = (sweep_rate != '0) || (sweep_bits != '0);
							if (sweep_bits != '0) begin
								nf = sweep_target();
								if (nf > 12'd2047)
									chan_live = 1'b0;
							end
						end
					end
					default: ;
				endcase
			end
			sqch_pkg::OP_READ: begin
				case (off)
					sqch_pkg::REG_SWEEP:
						res.read_data = sqch_pkg::RD_SWEEP_MSB
							| {1'b0, sweep_rate, sweep_down, sweep_bits};
					sqch_pkg::REG_DUTY:
						res.read_data = {wave_sel, 6'd0} | sqch_pkg::RD_DUTY_MASK;
					sqch_pkg::REG_ENV:
						res.read_data = {vol_start, env_rise, env_rate};
					sqch_pkg::REG_FREQ_HI:
						res.read_data = {1'b0, len_gate, 6'd0} | sqch_pkg::RD_HI_MASK;
					default:
						res.read_data = sqch_pkg::RD_NONE;
				endcase
			end
			sqch_pkg::OP_TIMER: begin
				// reload from the frequency, step the waveform, then count down
				if (period_left == '0) begin
					period_left = {sqch_pkg::PERIOD_BASE - {1'b0, freq_reg}, 2'b00};
					wave_pos    = wave_pos + 3'd1;
				end
				period_left = period_left - 14'd1;
			end
			sqch_pkg::OP_LENGTH: begin
				if (len_gate && len_left != '0) begin
					len_left = len_left - 7'd1;
					if (len_left == '0)
						chan_live = 1'b0;
				end
			end
			sqch_pkg::OP_ENVELOPE: begin
				// period zero freezes the envelope
				if (env_rate != '0) begin
					if (env_left != '0)
						env_left = env_left - 3'd1;
					if (env_left == '0) begin
						env_left = env_rate;
						if (env_rise && volume != 4'd15)
							volume = volume + 4'd1;
						else if (!env_rise && volume != 4'd0)
							volume = volume - 4'd1;
					end
				end
			end
			sqch_pkg::OP_SWEEP: begin
				if (sweep_left != '0)
					sweep_left = sweep_left - 4'd1;
				if (sweep_left == '0) begin
					sweep_left = (sweep_rate != '0) ? {1'b0, sweep_rate}
						: sqch_pkg::SWEEP_RELOAD;
					if (sweep_live && sweep_rate != '0) begin
						nf = sweep_target();
						if (nf > 12'd2047)
							chan_live = 1'b0;
						// a good result is taken, then checked once more for overflow
						if (nf <= 12'd2047 && sweep_bits != '0) begin
							freq_reg    = nf[10:0];
							freq_shadow = nf[10:0];
							nf = sweep_target();
							if (nf > 12'd2047)
								chan_live = 1'b0;
						end
					end
				end
			end
			default: ;
		endcase
		res.level   = (dac_on_bits != '0 && chan_live && DUTY_WAVES[{wave_sel, 3'd7 - wave_pos}])
			? volume : 4'd0;
		res.enabled = chan_live;
		chan_out_q.push_back(res);
	endtask

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------

	// mostly back to back, some short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (!tx_gaps_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 9);
		return $urandom_range(10, 30);
	endfunction

	// offer one item and hold it until taken; valid stays up on return
	task automatic send_item(input logic [2:0] ev, input logic [2:0] off, input logic [7:0] d);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= ev;
		reg_offset <= off;
		write_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		apply_event(ev, off, d);
		items_sent++;
		if (ev <= sqch_pkg::OP_SWEEP
			&& !(ev == sqch_pkg::OP_WRITE && off > sqch_pkg::REG_FREQ_HI))
			counted_items++;
	endtask

	// one event of the running mix, weighted toward timer clocks
	task automatic send_mixed_event();
		int         pick;
		logic [2:0] off;
		logic [7:0] d;
		pick = $urandom_range(0, 99);
		off  = 3'($urandom_range(0, 7));
		d    = 8'($urandom);
		if (pick < 40)
			send_item(sqch_pkg::OP_TIMER, off, d);
		else if (pick < 52)
			send_item(sqch_pkg::OP_LENGTH, off, d);
		else if (pick < 64)
			send_item(sqch_pkg::OP_ENVELOPE, off, d);
		else if (pick < 76)
			send_item(sqch_pkg::OP_SWEEP, off, d);
		else if (pick < 88)
			send_item(sqch_pkg::OP_READ, off, d);
		else if (pick < 96) begin
			off = 3'($urandom_range(0, 4));
			send_item(sqch_pkg::OP_WRITE, off, d);
		end else
			send_item(pick[0] ? OP_UNUSED7 : OP_UNUSED6, off, d);
	endtask

	// set up the channel, trigger it and let it run for a while
	task automatic play_note(input int n_events);
		logic [7:0] d;
		if ($urandom_range(0, 9) < 7) begin
			d = 8'($urandom);
			if ($urandom_range(0, 2) == 0)
				d[2:0] = 3'd0;
			send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_SWEEP, d);
		end
		if ($urandom_range(0, 9) < 7) begin
			d = 8'($urandom);
			// short lengths so the length counter runs out now and then
			if ($urandom_range(0, 9) < 4)
				d[5:0] = 6'($urandom_range(56, 63));
			send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_DUTY, d);
		end
		if ($urandom_range(0, 9) < 8) begin
			d = 8'($urandom);
			if (d[7:3] == '0 && $urandom_range(0, 5) != 0)
				d[7:4] = 4'($urandom_range(1, 15));
			send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_ENV, d);
		end
		if ($urandom_range(0, 9) < 7) begin
			d = 8'($urandom);
			if ($urandom_range(0, 1) == 1)
				d = 8'($urandom_range(8'hE0, 8'hFF));
			send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_FREQ_LO, d);
		end
		// high frequencies keep the timer period short enough to walk the waveform
		d = 8'($urandom);
		d[7] = 1'b1;
		if ($urandom_range(0, 9) < 7)
			d[2:0] = 3'd7;
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_FREQ_HI, d);
		repeat (n_events) send_mixed_event();
	endtask

	// anything at all, offsets and ops outside the map included
	task automatic send_noise(input int n);
		logic [2:0] ev;
		logic [2:0] off;
		logic [7:0] d;
		repeat (n) begin
			ev  = 3'($urandom_range(0, 7));
			off = 3'($urandom_range(0, 7));
			d   = 8'($urandom);
			send_item(ev, off, d);
		end
	endtask

	// ------------------------------------------------------------------
	// test cases
	// ------------------------------------------------------------------

	// every register read back, dac-off trigger, unmapped offsets and ops
	task automatic test_register_access();
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_SWEEP, 8'h7F);
		send_item(sqch_pkg::OP_READ, sqch_pkg::REG_SWEEP, 8'h00);
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_DUTY, 8'hFF);
		send_item(sqch_pkg::OP_READ, sqch_pkg::REG_DUTY, 8'h00);
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_ENV, 8'h00);
		send_item(sqch_pkg::OP_READ, sqch_pkg::REG_ENV, 8'h00);
		// trigger ignored with the dac off, frequency and length enable still land
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_FREQ_HI, 8'hC7);
		send_item(sqch_pkg::OP_READ, sqch_pkg::REG_FREQ_HI, 8'h00);
		send_item(sqch_pkg::OP_READ, sqch_pkg::REG_FREQ_LO, 8'h00);
		send_item(sqch_pkg::OP_WRITE, REG_UNUSED7, 8'hFF);
		send_item(sqch_pkg::OP_READ, REG_UNUSED5, 8'hFF);
		send_item(OP_UNUSED6, REG_UNUSED6, 8'h00);
		send_item(OP_UNUSED7, REG_UNUSED7, 8'hFF);
	endtask

	// overflow at trigger, overflow after an update, and sweep period zero
	task automatic test_sweep_cases();
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_ENV, 8'hF8);
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_SWEEP, 8'h11);
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_FREQ_LO, 8'hFF);
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_FREQ_HI, 8'h87);
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_FREQ_HI, 8'h83);
		// update is accepted, the follow-up calculation overflows
		send_item(sqch_pkg::OP_SWEEP, sqch_pkg::REG_SWEEP, 8'h00);
		// counter at one, period now zero: reload with eight, no update
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_SWEEP, 8'h01);
		send_item(sqch_pkg::OP_SWEEP, sqch_pkg::REG_SWEEP, 8'h00);
	endtask

	// envelope saturation and halt, length expiry
	task automatic test_envelope_and_length();
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_SWEEP, 8'h00);
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_ENV, 8'hE9);
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_DUTY, 8'hFE);
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_FREQ_HI, 8'hC7);
		send_item(sqch_pkg::OP_ENVELOPE, sqch_pkg::REG_ENV, 8'h00);
		send_item(sqch_pkg::OP_ENVELOPE, sqch_pkg::REG_ENV, 8'h00);
		send_item(sqch_pkg::OP_LENGTH, sqch_pkg::REG_DUTY, 8'h00);
		send_item(sqch_pkg::OP_LENGTH, sqch_pkg::REG_DUTY, 8'h00);
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_ENV, 8'h08);
		send_item(sqch_pkg::OP_ENVELOPE, sqch_pkg::REG_ENV, 8'h00);
	endtask

	// timer reload at the shortest period, waveform stepping
	task automatic test_timer_and_duty();
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_ENV, 8'hF0);
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_FREQ_LO, 8'hFF);
		send_item(sqch_pkg::OP_WRITE, sqch_pkg::REG_FREQ_HI, 8'h87);
		repeat (5) send_item(sqch_pkg::OP_TIMER, sqch_pkg::REG_FREQ_LO, 8'h00);
	endtask

	// mostly well-formed notes with random content, some noise
	task automatic test_random_traffic(input int n_items);
		int stop_at;
		stop_at = counted_items + n_items;
		while (counted_items < stop_at) begin
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) != 0)
				play_note($urandom_range(8, 30));
			else
				send_noise($urandom_range(2, 8));
		end
		tx_gaps_on = 1'b1;
	endtask

	// receiver holds off while items keep coming, so the input backs up
	task automatic test_output_stall();
		tx_gaps_on     = 1'b0;
		long_stall_req = 1'b1;
		play_note(40);
		tx_gaps_on     = 1'b1;
	endtask

	// stop sending until every owed result is out, then carry on
	task automatic test_pause_for_drain();
		play_note(12);
		in_valid <= 1'b0;
		do @(posedge clk); while (chan_out_q.size() != 0);
		play_note(12);
	endtask

	// ------------------------------------------------------------------
	// output side: ready pattern, long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				rx_hold_left   = LONG_STALL_CYCLES;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_ready <= 1'b0;
			end else begin
				// switch between always-ready stretches and choppy ones
				if (rx_mode_left == 0) begin
					rx_choppy    = ($urandom_range(0, 2) != 0);
					rx_mode_left = $urandom_range(20, 120);
				end else
					rx_mode_left--;
				if (rx_choppy && $urandom_range(0, 39) == 0)
					rx_hold_left = $urandom_range(8, 25);
				out_ready <= !rx_choppy || ($urandom_range(0, 3) != 0);
			end
		end
	end

	// result checker, compares against the oldest owed result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			got.read_data = read_data;
			got.level     = sample_out;
			got.enabled   = channel_on;
			if (got.enabled === 1'b1)
				on_results++;
			if (got.level != 4'd0)
				audible++;
			if (chan_out_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result with nothing owed: read_data %h sample %h on %b",
						$realtime, got.read_data, got.level, got.enabled);
			end else begin
				want = chan_out_q.pop_front();
				if (got.read_data !== want.read_data || got.level !== want.level
					|| got.enabled !== want.enabled) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result %0d: expected rd %h smp %h on %b, got rd %h smp %h on %b",
							$realtime, results_seen,
							want.read_data, want.level, want.enabled,
							got.read_data, got.level, got.enabled);
				end
			end
		end
	end

	// watchdog: too long with nothing moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (in_valid && !in_ready)
			in_stall_count++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d results still owed",
				$realtime, idle_cycles, chan_out_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_register_access();
		test_sweep_cases();
		test_envelope_and_length();
		test_timer_and_duty();
		test_random_traffic(RANDOM_ITEMS);
		test_output_stall();
		test_pause_for_drain();
		in_valid <= 1'b0;

		// let the last results out, then a few quiet cycles to catch strays
		while (chan_out_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d items (%0d not ignored), checked %0d results, input held off %0d cycles",
			items_sent, counted_items, results_seen, in_stall_count);
		$display("results with channel on: %0d, with nonzero sample: %0d, mismatches: %0d",
			on_results, audible, mismatches);
		if (mismatches == 0 && chan_out_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* square_channel_with_sweep.f */
design/sqch_pkg.sv
design/sqch_sweep_calc.sv
design/square_channel_with_sweep.sv
verif/square_channel_with_sweep_tb.sv
